[hw/rtl/accumulator_machine_execute_top_macros.svh]
// assertion macros used by the checker file
`ifndef ACCUMULATOR_MACHINE_EXECUTE_TOP_MACROS_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ACM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("acm check failed");

// next-cycle implication, disabled while in reset
`define ACM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("acm check failed");

`endif

[hw/rtl/acm_pkg.sv]
package acm_pkg;

	// command codes
	localparam logic [4:0] CMD_LOAD     = 5'd0;
	localparam logic [4:0] CMD_STORE    = 5'd1;
	localparam logic [4:0] CMD_LOAD_MQ  = 5'd2;
	localparam logic [4:0] CMD_MQ_LOAD  = 5'd3;
	localparam logic [4:0] CMD_LOAD_NEG = 5'd4;
	localparam logic [4:0] CMD_LOAD_ABS = 5'd5;
	localparam logic [4:0] CMD_LOAD_NAB = 5'd6;
	localparam logic [4:0] CMD_JUMP     = 5'd7;
	localparam logic [4:0] CMD_JUMP_POS = 5'd8;
	localparam logic [4:0] CMD_ADD      = 5'd9;
	localparam logic [4:0] CMD_ADD_ABS  = 5'd10;
	localparam logic [4:0] CMD_SUB      = 5'd11;
	localparam logic [4:0] CMD_SUB_ABS  = 5'd12;
	localparam logic [4:0] CMD_MUL      = 5'd13;
	localparam logic [4:0] CMD_DIV      = 5'd14;
	localparam logic [4:0] CMD_DOUBLE   = 5'd15;
	localparam logic [4:0] CMD_HALVE    = 5'd16;
	localparam logic [4:0] CMD_PRELOAD  = 5'd17;

	// stream word widths
	localparam int unsigned IN_BITS  = 48;
	localparam int unsigned OUT_BITS = 80;

	// request into the multiply/divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

	// status back from the multiply/divide unit
	typedef struct packed {
		logic busy;
		logic done;
	} md_rsp_t;

endpackage

[hw/rtl/acm_ram.sv]
module acm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

[hw/rtl/acm_muldiv.sv]
module acm_muldiv #(
	parameter int unsigned WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  acm_pkg::md_req_t     req,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	output acm_pkg::md_rsp_t     rsp,
	output logic [WORD_BITS-1:0] res_main,
	output logic [WORD_BITS-1:0] res_rem
);

	import acm_pkg::*;

	localparam int unsigned CW = $clog2(WORD_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic                 is_div_q;
	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] quo_q;
	logic [WORD_BITS:0]   trial;
	logic [WORD_BITS:0]   diff;

	// one restoring divide step: shift in the next dividend bit, try to subtract
	assign trial = {acc_q, x_q[WORD_BITS-1]};
	assign diff  = trial - {1'b0, y_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add multiply or restoring divide, one bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			is_div_q <= req.is_div;
			x_q      <= a;
			y_q      <= b;
			acc_q    <= '0;
			quo_q    <= '0;
		end else if (busy_q) begin
			x_q <= x_q << 1;
			if (is_div_q) begin
				if (!diff[WORD_BITS]) begin
					acc_q <= diff[WORD_BITS-1:0];
					quo_q <= {quo_q[WORD_BITS-2:0], 1'b1};
				end else begin
					acc_q <= trial[WORD_BITS-1:0];
					quo_q <= {quo_q[WORD_BITS-2:0], 1'b0};
				end
			end else begin
				y_q <= y_q >> 1;
				if (y_q[0]) begin
					acc_q <= acc_q + x_q;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign res_main = is_div_q ? quo_q : acc_q;
	assign res_rem  = acc_q;

endmodule

[hw/rtl/accumulator_machine_execute_top.sv]
// channel | dir | word                        | handshake
// s_*     | in  | command, address, value     | s_tvalid / s_tready
// m_*     | out | ac, mq, pc, divide error    | m_tvalid / m_tready
//
// an item passes the idle, address, execute and done states, plus the reduction
// of the address modulo memory size when that is below 1024 (one subtract a cycle),
// plus a wait on the bit-serial multiply/divide unit for multiply and a nonzero divide
// after reset the word memory is cleared, one word a cycle;
// s_tready stays low until then
// a result waiting on m_tready holds the next item at its last step
module accumulator_machine_execute_top #(
	parameter int unsigned MEM_WORDS = 1024,
	parameter int unsigned WORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// command [4:0], address [14:5], value [46:15], zero [47]
	input  logic [acm_pkg::IN_BITS-1:0]  s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// accumulator [31:0], quotient_register [63:32], program_counter [73:64],
	// divide_error [74], zero [79:75]
	output logic [acm_pkg::OUT_BITS-1:0] m_tdata
);

	import acm_pkg::*;

	localparam int unsigned AW = $clog2(MEM_WORDS);
	localparam int unsigned XW = (AW > 10) ? AW : 10;
	localparam int unsigned WX = (WORD_BITS > 32) ? WORD_BITS : 32;
	localparam int unsigned PW = (AW > 17) ? AW : 17;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ADDR  = 3'd2;
	localparam logic [2:0] ST_EXEC  = 3'd3;
	localparam logic [2:0] ST_MD    = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]           state_q;
	logic [AW:0]          clr_q;
	logic [4:0]           cmd_q;
	logic [9:0]           addr_q;
	logic [31:0]          value_q;
	logic [WORD_BITS-1:0] ac_q;
	logic [WORD_BITS-1:0] mq_q;
	logic [AW-1:0]        pc_q;
	logic                 derr_q;
	logic                 ac_neg_q;
	logic                 sign_diff_q;
	logic                 m_tvalid_q;
	logic [OUT_BITS-1:0]  m_tdata_q;

	logic                 in_acc;
	logic                 addr_big;
	logic [XW-1:0]        addr_x;
	logic [AW-1:0]        addr_w;
	logic                 ram_en;
	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] ram_rdata_w;
	logic [WORD_BITS-1:0] m_word;
	logic [WORD_BITS-1:0] m_abs;
	logic [WORD_BITS-1:0] ac_abs;
	logic [WORD_BITS-1:0] ac_half;
	logic [WORD_BITS-1:0] pre_word;
	logic [AW-1:0]        pc_inc;
	logic                 out_free;
	md_req_t              md_req;
	md_rsp_t              md_rsp;
	logic [WORD_BITS-1:0] md_a;
	logic [WORD_BITS-1:0] md_b;
	logic [WORD_BITS-1:0] md_main;
	logic [WORD_BITS-1:0] md_rem;
	logic [WX-1:0]        ac_x;
	logic [WX-1:0]        mq_x;
	logic [XW-1:0]        pc_x;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// address reduction modulo memory size
	assign addr_big = (PW'(addr_q) >= PW'(MEM_WORDS));
	assign addr_x   = XW'(addr_q);
	assign addr_w   = addr_x[AW-1:0];

	// operand helpers
	assign m_word   = ram_rdata_w;
	assign m_abs    = m_word[WORD_BITS-1] ? (~m_word + 1'b1) : m_word;
	assign ac_abs   = ac_q[WORD_BITS-1] ? (~ac_q + 1'b1) : ac_q;
	assign ac_half  = WORD_BITS'($signed(ac_q + WORD_BITS'(ac_q[WORD_BITS-1])) >>> 1);
	assign pre_word = WORD_BITS'($signed(value_q));
	assign pc_inc   = (pc_q == AW'(MEM_WORDS - 1)) ? '0 : pc_q + 1'b1;

	// memory port: clearing sweep, operand read, store
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = addr_w;
		ram_wdata = ac_q;
		if (state_q == ST_CLEAR) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = clr_q[AW-1:0];
			ram_wdata = '0;
		end else if (state_q == ST_ADDR) begin
			ram_en = !addr_big;
		end else if (state_q == ST_EXEC) begin
			if (cmd_q == CMD_STORE) begin
				ram_en = 1'b1;
				ram_we = 1'b1;
			end else if (cmd_q == CMD_PRELOAD) begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = pre_word;
			end
		end
	end

	acm_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MEM_WORDS)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata_w)
	);

	// multiply/divide request
	always_comb begin
		md_req.start  = 1'b0;
		md_req.is_div = (cmd_q == CMD_DIV);
		md_a          = mq_q;
		md_b          = m_word;
		if (state_q == ST_EXEC) begin
			if (cmd_q == CMD_MUL) begin
				md_req.start = 1'b1;
			end else if (cmd_q == CMD_DIV && m_word != '0) begin
				md_req.start = 1'b1;
				md_a         = ac_abs;
				md_b         = m_abs;
			end
		end
	end

	acm_muldiv #(
		.WORD_BITS(WORD_BITS)
	) u_muldiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (md_req),
		.a       (md_a),
		.b       (md_b),
		.rsp     (md_rsp),
		.res_main(md_main),
		.res_rem (md_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			ac_q    <= '0;
			mq_q    <= '0;
			pc_q    <= '0;
			derr_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(MEM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					if (!addr_big) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					derr_q  <= 1'b0;
					state_q <= ST_DONE;
					if (cmd_q <= CMD_HALVE) begin
						pc_q <= pc_inc;
					end
					case (cmd_q)
						CMD_LOAD:     ac_q <= m_word;
						CMD_LOAD_MQ:  ac_q <= mq_q;
						CMD_MQ_LOAD:  mq_q <= m_word;
						CMD_LOAD_NEG: ac_q <= ~m_word + 1'b1;
						CMD_LOAD_ABS: ac_q <= m_abs;
						CMD_LOAD_NAB: ac_q <= ~m_abs + 1'b1;
						CMD_JUMP:     pc_q <= addr_w;
						CMD_JUMP_POS: begin
							if (!ac_q[WORD_BITS-1]) begin
								pc_q <= addr_w;
							end
						end
						CMD_ADD:      ac_q <= ac_q + m_word;
						CMD_ADD_ABS:  ac_q <= ac_q + m_abs;
						CMD_SUB:      ac_q <= ac_q - m_word;
						CMD_SUB_ABS:  ac_q <= ac_q - m_abs;
						CMD_MUL:      state_q <= ST_MD;
						CMD_DIV: begin
							if (m_word == '0) begin
								derr_q <= 1'b1;
							end else begin
								state_q <= ST_MD;
							end
						end
						CMD_DOUBLE:   ac_q <= ac_q << 1;
						CMD_HALVE:    ac_q <= ac_half;
						default: ;
					endcase
				end
				ST_MD: begin
					if (md_rsp.done) begin
						state_q <= ST_DONE;
						if (cmd_q == CMD_DIV) begin
							mq_q <= sign_diff_q ? (~md_main + 1'b1) : md_main;
							ac_q <= ac_neg_q ? (~md_rem + 1'b1) : md_rem;
						end else begin
							ac_q <= md_main;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture, address reduction and divide signs
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= s_tdata[4:0];
			addr_q  <= s_tdata[14:5];
			value_q <= s_tdata[46:15];
		end else if (state_q == ST_ADDR && addr_big) begin
			addr_q <= 10'(PW'(addr_q) - PW'(MEM_WORDS));
		end
		if (state_q == ST_EXEC) begin
			ac_neg_q    <= ac_q[WORD_BITS-1];
			sign_diff_q <= ac_q[WORD_BITS-1] ^ m_word[WORD_BITS-1];
		end
	end

	assign ac_x = WX'(ac_q);
	assign mq_x = WX'(mq_q);
	assign pc_x = XW'(pc_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {5'd0, derr_q, pc_x[9:0], mq_x[31:0], ac_x[31:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[hw/rtl/acm_checker.sv]
`include "accumulator_machine_execute_top_macros.svh"

module acm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [acm_pkg::OUT_BITS-1:0] m_tdata
);

	// one item at a time: no second word straight after an accepted one
	`ACM_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// padding above the divide flag is always zero
	`ACM_ASSERT_NOW(a_out_pad, clk, arst_n, m_tvalid, m_tdata[acm_pkg::OUT_BITS-1:75] == '0)

	// stalled result stays offered
	`ACM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// stalled result holds its word
	`ACM_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind accumulator_machine_execute_top acm_checker u_acm_checker (.*);
